// ===== hw/rtl/sle_pkg.sv =====
// Package for the serial line editor: character codes, line status codes,
// the result record and the limit constants. No dependencies.
package sle_pkg;

    localparam int LINE_MAX  = 256;
    localparam int LIMIT_TOP = (LINE_MAX < 256) ? LINE_MAX : 256;
    localparam int FIFO_DEPTH = 4;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

    localparam logic [7:0] CH_CTRL_C = 8'h03;
    localparam logic [7:0] CH_BS     = 8'h08;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TILDE  = 8'h7E;
    localparam logic [7:0] CH_DEL    = 8'h7F;

    localparam logic [8:0] LIM_REG_RESET = 9'd256;

    typedef enum logic [1:0] {
        ST_BUSY  = 2'd0,
        ST_EOL   = 2'd1,
        ST_ABORT = 2'd2,
        ST_FULL  = 2'd3
    } line_status_t;

    typedef struct packed {
        logic         echo_valid;
        logic [7:0]   echo_byte;
        logic         store_valid;
        logic [7:0]   store_index;
        logic [7:0]   store_byte;
        line_status_t line_status;
        logic [7:0]   line_length;
        logic         last_result;
    } result_t;

    // limit minus one, from the raw register value
    function automatic logic [7:0] limit_m1(input logic [8:0] v);
        logic [8:0] lim;
        lim = v;
        if (lim < 9'd2) lim = 9'd2;
        if (lim > 9'(LIMIT_TOP)) lim = 9'(LIMIT_TOP);
        return 8'(lim - 9'd1);
    endfunction

endpackage

// ===== hw/rtl/serial_line_editor.sv =====
// Top level of the serial line editor: limit register, decoder and result queue.
// Depends on sle_pkg, sle_core and sle_fifo.
//
//  channel | handshake             | payload
//  --------+-----------------------+-------------------------------------------
//  in      | in_valid / in_stall   | rx_byte
//  out     | out_valid / out_stall | echo_*, store_*, line_status, line_length,
//          |                       | last_result
//  cfg     | cfg_valid / cfg_ready | cfg_data (max_line_length)
//
// One byte per cycle while in_stall is low; a request is decoded in the cycle it is
// taken; results leave a four-entry queue one per cycle while out_stall is low.
// in_stall rises while the queue lacks room for two results.
// Reset clears the fill count, empties the queue and sets the limit to 256.
// cfg is always ready.
module serial_line_editor import sle_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] rx_byte,
    output logic       out_valid,
    input  logic       out_stall,
    output logic       echo_valid,
    output logic [7:0] echo_byte,
    output logic       store_valid,
    output logic [7:0] store_index,
    output logic [7:0] store_byte,
    output logic [1:0] line_status,
    output logic [7:0] line_length,
    output logic       last_result,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [8:0] cfg_data
);

    logic [7:0] lim_m1_reg;
    logic       accept;
    logic       room2;
    result_t    res0;
    result_t    res1;
    result_t    head;
    logic [1:0] res_count;
    logic [1:0] push_count;

    assign cfg_ready = 1'b1;
    assign in_stall  = !room2;
    assign accept    = in_valid && room2;
    assign push_count = accept ? res_count : 2'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            lim_m1_reg <= limit_m1(LIM_REG_RESET);
        else if (cfg_valid && cfg_ready)
            lim_m1_reg <= limit_m1(cfg_data);
    end

    sle_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .rx_byte   (rx_byte),
        .lim_m1    (lim_m1_reg),
        .res0      (res0),
        .res1      (res1),
        .res_count (res_count)
    );

    sle_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_count (push_count),
        .push0      (res0),
        .push1      (res1),
        .pop        (out_valid && !out_stall),
        .room2      (room2),
        .not_empty  (out_valid),
        .head       (head)
    );

    assign echo_valid  = head.echo_valid;
    assign echo_byte   = head.echo_byte;
    assign store_valid = head.store_valid;
    assign store_index = head.store_index;
    assign store_byte  = head.store_byte;
    assign line_status = head.line_status;
    assign line_length = head.line_length;
    assign last_result = head.last_result;

endmodule

// ===== hw/rtl/sle_core.sv =====
// Byte decoder and fill count for the serial line editor.
// Produces up to two result records per accepted byte. Uses sle_pkg.
module sle_core import sle_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       accept,
    input  logic [7:0] rx_byte,
    input  logic [7:0] lim_m1,
    output result_t    res0,
    output result_t    res1,
    output logic [1:0] res_count
);

    logic [7:0] fill_reg;
    logic [7:0] fill_next;
    logic [7:0] mid;
    logic       first;
    logic       is_print;
    logic       is_bs;
    result_t    full_res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fill_reg <= 8'd0;
        else if (accept)
            fill_reg <= fill_next;
    end

    always_comb
    begin
        is_print  = (rx_byte >= CH_SPACE) && (rx_byte <= CH_TILDE);
        is_bs     = ((rx_byte == CH_DEL) || (rx_byte == CH_BS)) && (fill_reg != 8'd0);
        res0      = '0;
        res1      = '0;
        res_count = 2'd0;
        fill_next = fill_reg;
        mid       = fill_reg;
        first     = 1'b0;
        full_res  = '0;
        if ((rx_byte == CH_CR) || (rx_byte == CH_LF))
        begin
            res0.store_valid = 1'b1;
            res0.store_index = fill_reg;
            res0.line_status = ST_EOL;
            res0.line_length = fill_reg;
            res0.last_result = 1'b1;
            res_count        = 2'd1;
            fill_next        = 8'd0;
        end
        else if (rx_byte == CH_CTRL_C)
        begin
            res0.store_valid = 1'b1;
            res0.line_status = ST_ABORT;
            res0.last_result = 1'b1;
            res_count        = 2'd1;
            fill_next        = 8'd0;
        end
        else
        begin
            if (is_print)
            begin
                res0.echo_valid  = 1'b1;
                res0.echo_byte   = rx_byte;
                res0.store_valid = 1'b1;
                res0.store_index = fill_reg;
                res0.store_byte  = rx_byte;
                res0.last_result = 1'b1;
                mid              = fill_reg + 8'd1;
                first            = 1'b1;
            end
            else if (is_bs)
            begin
                res0.echo_valid  = 1'b1;
                res0.echo_byte   = rx_byte;
                res0.last_result = 1'b1;
                mid              = fill_reg - 8'd1;
                first            = 1'b1;
            end
            fill_next = mid;
            res_count = {1'b0, first};
            full_res.store_valid = 1'b1;
            full_res.store_index = mid;
            full_res.line_status = ST_FULL;
            full_res.line_length = mid;
            full_res.last_result = 1'b1;
            if (mid >= lim_m1)
            begin
                fill_next = 8'd0;
                if (first)
                begin
                    res0.last_result = 1'b0;
                    res1             = full_res;
                    res_count        = 2'd2;
                end
                else
                begin
                    res0      = full_res;
                    res_count = 2'd1;
                end
            end
        end
    end

endmodule

// ===== hw/rtl/sle_fifo.sv =====
// Result queue for the serial line editor: takes up to two records a cycle,
// hands out one when popped. Uses sle_pkg.
module sle_fifo import sle_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic [1:0] push_count,
    input  result_t    push0,
    input  result_t    push1,
    input  logic       pop,
    output logic       room2,
    output logic       not_empty,
    output result_t    head
);

    result_t           mem_reg [FIFO_DEPTH];
    logic [PTR_W-1:0]  wr_reg;
    logic [PTR_W-1:0]  rd_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [PTR_W-1:0]  wr_plus1;

    assign wr_plus1  = wr_reg + PTR_W'(1);
    assign not_empty = (cnt_reg != '0);
    assign room2     = (cnt_reg <= CNT_W'(FIFO_DEPTH - 2));
    assign head      = mem_reg[rd_reg];

    always_ff @(posedge clk)
    begin
        if (push_count != 2'd0)
            mem_reg[wr_reg] <= push0;
        if (push_count == 2'd2)
            mem_reg[wr_plus1] <= push1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_reg + PTR_W'(push_count);
            if (pop)
                rd_reg <= rd_reg + PTR_W'(1);
            cnt_reg <= cnt_reg + CNT_W'(push_count) - CNT_W'(pop);
        end
    end

endmodule

// ===== hw/rtl/sle_checker.sv =====
// Port-level checks for serial_line_editor, attached by bind.
// Uses sle_pkg.
module sle_checker import sle_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       out_valid,
    input  logic       out_stall,
    input  logic       echo_valid,
    input  logic       store_valid,
    input  logic [7:0] store_index,
    input  logic [7:0] store_byte,
    input  logic [1:0] line_status,
    input  logic [7:0] line_length,
    input  logic       last_result
);

    // a stalled result stays
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped while stalled");

    // every line end writes a terminator
    a_end_term: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && line_status != ST_BUSY |-> store_valid && store_byte == 8'd0)
        else $error("line end without terminator");

    a_abort: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && line_status == ST_ABORT |-> store_index == 8'd0 && line_length == 8'd0)
        else $error("abort not at index zero");

    // only an echoed byte can be followed by a full-line result
    a_first_of_two: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last_result |-> echo_valid && line_status == ST_BUSY)
        else $error("bad first result of a pair");

endmodule

bind serial_line_editor sle_checker u_sle_checker (.*);

// ===== tb/tb_serial_line_editor.sv =====
// Self-checking testbench for serial_line_editor: directed and random byte streams,
// limit register changes between phases, random input gaps and random result stalls.
// Depends on sle_pkg and the serial_line_editor RTL.
module tb_serial_line_editor;
    timeunit 1ns;
    timeprecision 1ps;

    import sle_pkg::*;

    localparam int SETTLE_CYCLES  = 6;
    localparam int HOLD_CYCLES    = 64;
    localparam int HOLD_AFTER     = 150;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int MAX_REPORTS    = 10;

    logic       clk;
    logic       rst_n       = 1'b0;
    logic       in_valid    = 1'b0;
    logic [7:0] rx_byte     = 8'h00;
    logic       out_stall   = 1'b0;
    logic       cfg_valid   = 1'b0;
    logic [8:0] cfg_data    = 9'd0;
    logic       in_stall;
    logic       out_valid;
    logic       echo_valid;
    logic [7:0] echo_byte;
    logic       store_valid;
    logic [7:0] store_index;
    logic [7:0] store_byte;
    logic [1:0] line_status;
    logic [7:0] line_length;
    logic       last_result;
    logic       cfg_ready;

    logic [7:0] pending_bytes [$];
    result_t    line_results_due [$];
    logic [7:0] model_fill  = 8'd0;
    logic [8:0] model_limit = LIM_REG_RESET;

    int idle_pct     = 37;
    int fail_count   = 0;
    int results_seen = 0;
    int hold_left    = 0;
    bit hold_done    = 1'b0;
    int quiet_cycles = 0;

    result_t got_res;
    result_t want_res;

    logic [7:0] directed_bytes [$] = '{
        CH_SPACE, CH_TILDE, 8'h41, CH_BS, CH_DEL, CH_BS, CH_BS, CH_DEL,
        8'h00, 8'hFF, 8'h80, 8'h1F, 8'h5A, CH_CR, 8'h61, 8'h62, CH_LF, CH_LF,
        8'h63, CH_CTRL_C, CH_CTRL_C, CH_CR, 8'h41, 8'h42, 8'h43
    };

    serial_line_editor uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .rx_byte    (rx_byte),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .echo_valid (echo_valid),
        .echo_byte  (echo_byte),
        .store_valid(store_valid),
        .store_index(store_index),
        .store_byte (store_byte),
        .line_status(line_status),
        .line_length(line_length),
        .last_result(last_result),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic result_t mk_result(input logic ev, input logic [7:0] eb,
                                          input logic sv, input logic [7:0] si,
                                          input logic [7:0] sb, input line_status_t st,
                                          input logic [7:0] len, input logic last);
        result_t r;
        r.echo_valid  = ev;
        r.echo_byte   = eb;
        r.store_valid = sv;
        r.store_index = si;
        r.store_byte  = sb;
        r.line_status = st;
        r.line_length = len;
        r.last_result = last;
        return r;
    endfunction

    // line editor behavior for one received byte; queues the results it causes
    function automatic void edit_byte(input logic [7:0] c);
        int      lim;
        bit      has_echo;
        result_t first;
        lim = int'(model_limit);
        if (lim < 2) lim = 2;
        if (lim > LIMIT_TOP) lim = LIMIT_TOP;
        has_echo = 1'b0;
        first = '0;
        if (c == CH_CR || c == CH_LF)
        begin
            line_results_due.push_back(mk_result(1'b0, 8'd0, 1'b1, model_fill, 8'd0,
                                                 ST_EOL, model_fill, 1'b1));
            model_fill = 8'd0;
        end
        else if (c == CH_CTRL_C)
        begin
            line_results_due.push_back(mk_result(1'b0, 8'd0, 1'b1, 8'd0, 8'd0,
                                                 ST_ABORT, 8'd0, 1'b1));
            model_fill = 8'd0;
        end
        else
        begin
            if (c >= CH_SPACE && c <= CH_TILDE)
            begin
                first = mk_result(1'b1, c, 1'b1, model_fill, c, ST_BUSY, 8'd0, 1'b1);
                has_echo = 1'b1;
                model_fill = model_fill + 8'd1;
            end
            else if ((c == CH_DEL || c == CH_BS) && model_fill != 8'd0)
            begin
                first = mk_result(1'b1, c, 1'b0, 8'd0, 8'd0, ST_BUSY, 8'd0, 1'b1);
                has_echo = 1'b1;
                model_fill = model_fill - 8'd1;
            end
            if (int'(model_fill) >= lim - 1)
            begin
                if (has_echo)
                begin
                    first.last_result = 1'b0;
                    line_results_due.push_back(first);
                end
                line_results_due.push_back(mk_result(1'b0, 8'd0, 1'b1, model_fill, 8'd0,
                                                     ST_FULL, model_fill, 1'b1));
                model_fill = 8'd0;
            end
            else if (has_echo)
            begin
                line_results_due.push_back(first);
            end
        end
    endfunction

    function automatic string fmt_result(input result_t r);
        return $sformatf("echo %0b/%02h store %0b @%02h=%02h status %0d len %0d last %0b",
                         r.echo_valid, r.echo_byte, r.store_valid, r.store_index,
                         r.store_byte, r.line_status, r.line_length, r.last_result);
    endfunction

    // long_lines: mostly printable, line ends only from random bytes, so the buffer can fill up
    function automatic logic [7:0] pick_byte(input bit long_lines);
        int r;
        r = $urandom_range(99);
        if (long_lines)
        begin
            if (r < 92) return 8'($urandom_range(32, 126));
            if (r < 95) return r[0] ? CH_BS : CH_DEL;
            return 8'($urandom_range(0, 255));
        end
        if (r < 68) return 8'($urandom_range(32, 126));
        if (r < 78) return r[0] ? CH_BS : CH_DEL;
        if (r < 86) return r[0] ? CH_CR : CH_LF;
        if (r < 89) return CH_CTRL_C;
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic add_random(input int n, input bit long_lines);
        repeat (n) pending_bytes.push_back(pick_byte(long_lines));
    endtask

    task automatic wait_idle();
        while (pending_bytes.size() != 0 || in_valid || line_results_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_limit(input logic [8:0] v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        model_limit = v;
        cfg_valid <= 1'b0;
    endtask

    task automatic run_phase(input logic [8:0] lim, input int n, input bit long_lines);
        write_limit(lim);
        add_random(n, long_lines);
        wait_idle();
    endtask

    // input driver
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && !in_stall)
                edit_byte(rx_byte);
            if (!in_valid || !in_stall)
            begin
                if (pending_bytes.size() != 0 && $urandom_range(99) >= idle_pct)
                begin
                    in_valid <= 1'b1;
                    rx_byte  <= pending_bytes.pop_front();
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor and receiver stalls
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                got_res = mk_result(echo_valid, echo_byte, store_valid, store_index,
                                    store_byte, line_status_t'(line_status),
                                    line_length, last_result);
                results_seen++;
                if (line_results_due.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS)
                        $display("unexpected result: %s", fmt_result(got_res));
                end
                else
                begin
                    want_res = line_results_due.pop_front();
                    if (got_res.echo_valid  !== want_res.echo_valid  ||
                        got_res.echo_byte   !== want_res.echo_byte   ||
                        got_res.store_valid !== want_res.store_valid ||
                        got_res.store_index !== want_res.store_index ||
                        got_res.store_byte  !== want_res.store_byte  ||
                        got_res.line_status !== want_res.line_status ||
                        got_res.line_length !== want_res.line_length ||
                        got_res.last_result !== want_res.last_result)
                    begin
                        fail_count++;
                        if (fail_count <= MAX_REPORTS)
                            $display("mismatch at %0t\n  expected: %s\n  actual:   %s",
                                     $realtime, fmt_result(want_res), fmt_result(got_res));
                    end
                end
            end
            // one long hold-off so the queue fills and the input stalls
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else if (!hold_done && results_seen >= HOLD_AFTER)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= ($urandom_range(99) < idle_pct);
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            quiet_cycles <= 0;
        end
        else if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
                 (cfg_valid && cfg_ready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_bytes[i]) pending_bytes.push_back(directed_bytes[i]);
        wait_idle();

        // lowered limit with a line still open
        write_limit(9'd2);
        pending_bytes.push_back(8'h00);
        add_random(100, 1'b0);
        wait_idle();

        run_phase(9'd0, 80, 1'b0);
        run_phase(9'd3, 120, 1'b0);
        run_phase(9'd511, 350, 1'b1);
        idle_pct = 0;
        run_phase(9'd8, 150, 1'b0);
        idle_pct = 37;
        run_phase(9'd1, 80, 1'b0);
        run_phase(9'd257, 150, 1'b0);
        run_phase(9'($urandom_range(2, 40)), 120, 1'b0);
        run_phase(9'($urandom_range(2, 40)), 120, 1'b0);
        run_phase(9'd256, 300, 1'b0);

        fail_count += line_results_due.size();
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
